// ===== rtl/sctrk_pkg.sv =====
package sctrk_pkg;

   // confidence levels of the phase fix
   localparam logic [4:0] FIX_NONE      = 5'd0;
   localparam logic [4:0] FIX_CANDIDATE = 5'd1;
   localparam logic [4:0] FIX_ACQUIRED  = 5'd4;
   localparam logic [4:0] FIX_FINAL     = 5'd16;

   // cycle index that the first cycle after reset follows
   localparam logic [31:0] LAST_CYCLE_RESET = 32'hFFFF_FFFF;

   // one sweep cycle with both sync pulse lengths
   typedef struct packed {
      logic [31:0] cycle_index;
      logic [15:0] pulse_len_first;
      logic [15:0] pulse_len_second;
   } item_type;

   // one result of the tracker
   typedef struct packed {
      logic [1:0] phase;
      logic       phase_valid;
      logic [4:0] confidence;
   } result_type;

   // tracker state carried from cycle to cycle
   typedef struct packed {
      logic [31:0] last_full_cycle;
      logic [1:0]  compare_history;
      logic [4:0]  fix_level;
      logic [1:0]  phase_offset;
   } track_state_type;

   // 2-bit compare history to measured phase
   function automatic logic [1:0] history_to_phase(input logic [1:0] history);
      logic [1:0] phase;
      case (history)
         2'd0:    phase = 2'd1;
         2'd1:    phase = 2'd2;
         2'd2:    phase = 2'd0;
         default: phase = 2'd3;
      endcase
      return phase;
   endfunction

endpackage

// ===== rtl/sctrk_channels.sv =====
// input channel: one sweep cycle per transfer
interface sctrk_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] cycle_index;
   logic [15:0] pulse_len_first;
   logic [15:0] pulse_len_second;

   modport source (
      output valid, cycle_index, pulse_len_first, pulse_len_second,
      input  ready
   );
   modport sink (
      input  valid, cycle_index, pulse_len_first, pulse_len_second,
      output ready
   );
endinterface

// result channel: one phase report per transfer
interface sctrk_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] phase;
   logic       phase_valid;
   logic [4:0] confidence;

   modport source (
      output valid, phase, phase_valid, confidence,
      input  ready
   );
   modport sink (
      input  valid, phase, phase_valid, confidence,
      output ready
   );
endinterface

// ===== rtl/sctrk_update.sv =====
module sctrk_update
   import sctrk_pkg::*;
(
   input  item_type        item,
   input  track_state_type state_cur,
   output track_state_type state_next,
   output result_type      result
);

   logic       both_present;
   logic       first_longer;
   logic       consecutive;
   logic [1:0] history_shifted;
   logic [1:0] measured;
   logic       have_phase;
   logic [1:0] expected;

   // pulse comparison and cycle continuity
   always_comb begin
      both_present    = (item.pulse_len_first != 16'd0) && (item.pulse_len_second != 16'd0);
      first_longer    = item.pulse_len_first > item.pulse_len_second;
      consecutive     = item.cycle_index == (state_cur.last_full_cycle + 32'd1);
      history_shifted = {state_cur.compare_history[0], first_longer};
      measured        = history_to_phase(history_shifted);
      have_phase      = both_present && consecutive;
      expected        = item.cycle_index[1:0] + state_cur.phase_offset;
   end

   // history and confidence update
   always_comb begin
      state_next = state_cur;
      if (both_present) begin
         state_next.last_full_cycle = item.cycle_index;
         state_next.compare_history = consecutive ? history_shifted : {1'b0, first_longer};
      end
      if (have_phase && (state_cur.fix_level < FIX_FINAL)) begin
         if (state_cur.fix_level == FIX_NONE) begin
            state_next.fix_level    = FIX_CANDIDATE;
            state_next.phase_offset = measured - item.cycle_index[1:0];
         end else if (measured == expected) begin
            state_next.fix_level = state_cur.fix_level + 5'd1;
         end else begin
            state_next.fix_level = state_cur.fix_level - 5'd1;
         end
      end
   end

   // report phase once acquired
   always_comb begin
      result.confidence  = state_next.fix_level;
      result.phase_valid = state_next.fix_level >= FIX_ACQUIRED;
      result.phase       = result.phase_valid ?
                           (item.cycle_index[1:0] + state_next.phase_offset) : 2'd0;
   end

endmodule

// ===== rtl/sweep_cycle_phase_tracker.sv =====
// Sweep cycle phase tracker: takes one sweep cycle per transfer and returns one phase
// report per transfer, in order. An accepted cycle is held in an input register until the
// result register is free or its report is taken; then the tracker state is updated and
// the report is written to it. One cycle is accepted every clock; the result
// register stalls the input side only while its report has not been taken. Both pulse
// lengths must be nonzero for a cycle to count; phase_valid rises once the confidence
// reaches 4, and confidence freezes at 16. Synchronous reset clears the tracker.
module sweep_cycle_phase_tracker
   import sctrk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sctrk_req_if.sink    req,
   sctrk_rsp_if.source  rsp
);

   logic            in_valid_ff;
   logic            in_valid_in;
   item_type        in_item_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      rsp_result_ff;
   track_state_type state_ff;
   track_state_type state_in;
   result_type      result_next;
   logic            advance;
   logic            req_fire;

   // handshake and stage advance
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // tracker update
   sctrk_update u_update (
      .item       (in_item_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (result_next)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.last_full_cycle <= LAST_CYCLE_RESET;
         state_ff.compare_history <= 2'd0;
         state_ff.fix_level       <= FIX_NONE;
         state_ff.phase_offset    <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.cycle_index      <= req.cycle_index;
         in_item_ff.pulse_len_first  <= req.pulse_len_first;
         in_item_ff.pulse_len_second <= req.pulse_len_second;
      end
      if (advance) begin
         rsp_result_ff <= result_next;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.phase       = rsp_result_ff.phase;
   assign rsp.phase_valid = rsp_result_ff.phase_valid;
   assign rsp.confidence  = rsp_result_ff.confidence;

   // confidence never passes the final level
   a_fix_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.fix_level <= FIX_FINAL)
      else $error("fix level above final");

   // final level is frozen
   a_fix_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff.fix_level == FIX_FINAL |=> state_ff.fix_level == FIX_FINAL)
      else $error("fix level left final");

   // confidence moves by at most one step per cycle
   a_fix_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (state_ff.fix_level == $past(state_ff.fix_level)) ||
               (state_ff.fix_level == $past(state_ff.fix_level) + 5'd1) ||
               (state_ff.fix_level == $past(state_ff.fix_level) - 5'd1))
      else $error("fix level jumped");

   // reported flag follows reported confidence
   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.phase_valid == (rsp_result_ff.confidence >= FIX_ACQUIRED)))
      else $error("phase_valid disagrees with confidence");

   // no phase without a fix
   a_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_result_ff.phase_valid) |-> rsp_result_ff.phase == 2'd0)
      else $error("phase reported without fix");

endmodule

// ===== verif/tb_sweep_cycle_phase_tracker.sv =====
module tb_sweep_cycle_phase_tracker;
   import sctrk_pkg::*;

   // tracker model and store of phase reports still due
   class phase_scoreboard;
      track_state_type track;
      result_type      reports_due[$];
      int              mismatch_count;
      logic [1:0]      phase_of_history [4];

      function new();
         track.last_full_cycle = LAST_CYCLE_RESET;
         track.compare_history = 2'd0;
         track.fix_level       = FIX_NONE;
         track.phase_offset    = 2'd0;
         mismatch_count        = 0;
         phase_of_history      = '{2'd1, 2'd2, 2'd0, 2'd3};
      endfunction

      function logic [4:0] level_now();
         return track.fix_level;
      endfunction

      function logic [1:0] offset_now();
         return track.phase_offset;
      endfunction

      function int reports_pending();
         return reports_due.size();
      endfunction

      // accepted sweep cycle: update the tracker and queue its report
      function void note_cycle(item_type cyc);
         logic       longer_first;
         logic       measured_ok;
         logic [1:0] measured;
         logic [1:0] predicted;
         result_type report;
         measured_ok = 1'b0;
         measured    = 2'd0;

         // both pulses present: form the compare bit
         if (cyc.pulse_len_first != 16'd0 && cyc.pulse_len_second != 16'd0) begin
            longer_first = cyc.pulse_len_first > cyc.pulse_len_second;
            if (cyc.cycle_index == track.last_full_cycle + 32'd1) begin
               track.compare_history = {track.compare_history[0], longer_first};
               measured    = phase_of_history[track.compare_history];
               measured_ok = 1'b1;
            end else begin
               track.compare_history = {1'b0, longer_first};
            end
            track.last_full_cycle = cyc.cycle_index;
         end

         // confidence walk, frozen once final
         if (measured_ok && track.fix_level < FIX_FINAL) begin
            if (track.fix_level == FIX_NONE) begin
               track.fix_level    = FIX_CANDIDATE;
               track.phase_offset = measured - cyc.cycle_index[1:0];
            end else begin
               predicted = cyc.cycle_index[1:0] + track.phase_offset;
               if (measured == predicted) begin
                  track.fix_level = track.fix_level + 5'd1;
               end else begin
                  track.fix_level = track.fix_level - 5'd1;
               end
            end
         end

         if (track.fix_level >= FIX_ACQUIRED) begin
            report.phase       = cyc.cycle_index[1:0] + track.phase_offset;
            report.phase_valid = 1'b1;
         end else begin
            report.phase       = 2'd0;
            report.phase_valid = 1'b0;
         end
         report.confidence = track.fix_level;
         reports_due.push_back(report);
      endfunction

      // accepted report: compare with the oldest one due
      function void check_report(result_type got);
         result_type want;
         if (reports_due.size() == 0) begin
            $display("%0t: report with none due: phase %0d valid %0d confidence %0d",
                     $time, got.phase, got.phase_valid, got.confidence);
            mismatch_count++;
            return;
         end
         want = reports_due.pop_front();
         if (got.phase !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
            mismatch_count++;
         end
         if (got.phase_valid !== want.phase_valid) begin
            $display("%0t: phase_valid expected %0d actual %0d",
                     $time, want.phase_valid, got.phase_valid);
            mismatch_count++;
         end
         if (got.confidence !== want.confidence) begin
            $display("%0t: confidence expected %0d actual %0d",
                     $time, want.confidence, got.confidence);
            mismatch_count++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   quiet_cycles;

   sctrk_req_if req_ch ();
   sctrk_rsp_if rsp_ch ();

   phase_scoreboard tracker_sb;

   sweep_cycle_phase_tracker i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      item_type   cyc;
      result_type report;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            cyc.cycle_index      = req_ch.cycle_index;
            cyc.pulse_len_first  = req_ch.pulse_len_first;
            cyc.pulse_len_second = req_ch.pulse_len_second;
            tracker_sb.note_cycle(cyc);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            report.phase       = rsp_ch.phase;
            report.phase_valid = rsp_ch.phase_valid;
            report.confidence  = rsp_ch.confidence;
            tracker_sb.check_report(report);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // one sweep cycle, with a random gap before it
   task automatic send_cycle(input logic [31:0] idx, input logic [15:0] len_first,
                             input logic [15:0] len_second);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.cycle_index      <= idx;
      req_ch.pulse_len_first  <= len_first;
      req_ch.pulse_len_second <= len_second;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // pulse pair whose compare bit is the one given; equal lengths give 0
   task automatic pulses_for_bit(input logic longer_first, output logic [15:0] len_first,
                                 output logic [15:0] len_second);
      if (longer_first) begin
         len_first  = 16'($urandom_range(2, 65535));
         len_second = 16'($urandom_range(1, len_first - 1));
      end else begin
         len_second = 16'($urandom_range(1, 65535));
         len_first  = 16'($urandom_range(1, len_second));
      end
   endtask

   // cycle of a well-formed pattern: bit 1 of (index + rotation), xor flip, gives the compare bit
   task automatic send_pattern_cycle(input logic [31:0] idx, input logic [1:0] rotation,
                                     input logic flip);
      logic [31:0] shifted;
      logic [15:0] len_first;
      logic [15:0] len_second;
      shifted = idx + {30'd0, rotation};
      pulses_for_bit(shifted[1] ^ flip, len_first, len_second);
      send_cycle(idx, len_first, len_second);
   endtask

   // hold the sender until every report has come back
   task automatic drain_reports();
      req_ch.valid <= 1'b0;
      while (tracker_sb.reports_pending() != 0) @(negedge clock);
   endtask

   // random part: mostly runs of consecutive cycles, some noise
   task automatic run_random(input int count);
      int          sent;
      int          run_len;
      int          k;
      logic [31:0] idx;
      logic [1:0]  rotation;
      logic [15:0] len_first;
      logic [15:0] len_second;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            // unrelated cycle, pulses often missing
            len_first  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            len_second = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            send_cycle($urandom, len_first, len_second);
            sent++;
         end else begin
            run_len = $urandom_range(2, 10);
            if ($urandom_range(0, 3) == 0) begin
               idx = 32'hFFFF_FFFF - $urandom_range(0, 6);
            end else begin
               idx = $urandom;
            end
            // favor the held offset while confidence is low, so the level moves both ways
            if ($urandom_range(0, 99) < ((tracker_sb.level_now() >= 5'd12) ? 20 : 60)) begin
               rotation = tracker_sb.offset_now();
            end else begin
               rotation = 2'($urandom_range(0, 3));
            end
            for (k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 99) < 4) begin
                  // one pulse or both missing
                  len_first  = ($urandom_range(0, 1) == 0) ? 16'd0 :
                               16'($urandom_range(1, 65535));
                  len_second = (len_first != 16'd0) ? 16'd0 :
                               16'($urandom_range(0, 65535));
                  send_cycle(idx, len_first, len_second);
               end else begin
                  send_pattern_cycle(idx, rotation, $urandom_range(0, 99) < 6);
               end
               sent++;
               idx = ($urandom_range(0, 99) < 3) ? idx + $urandom_range(2, 5) : idx + 32'd1;
            end
         end
      end
   endtask

   // stimulus
   initial begin
      int          i;
      logic [31:0] idx;
      tracker_sb              = new();
      quiet_cycles            = 0;
      send_idle_pct           = 36;
      recv_idle_pct           = 53;
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.cycle_index      = 32'd0;
      req_ch.pulse_len_first  = 16'd0;
      req_ch.pulse_len_second = 16'd0;
      rsp_ch.ready            = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // index 0 follows reset; equal lengths; candidate then mismatch down to none
      send_cycle(32'd0, 16'd1, 16'd1);
      send_cycle(32'd1, 16'hFFFF, 16'hFFFF);
      // missing pulses
      send_cycle(32'd2, 16'd0, 16'd5);
      send_cycle(32'd3, 16'd7, 16'd0);
      send_cycle(32'd4, 16'd0, 16'd0);
      // gap in the index restarts the history
      send_cycle(32'd5, 16'hFFFF, 16'd1);
      // clean run across the index wrap, through acquired
      for (i = 0; i < 13; i++) begin
         send_pattern_cycle(32'hFFFF_FFF8 + i, 2'd0, 1'b0);
      end
      // wrong compare bit steps the level down
      send_pattern_cycle(32'd5, 2'd0, 1'b1);
      send_cycle(32'd6, 16'd1, 16'hFFFF);
      send_cycle(32'd7, 16'h8000, 16'h7FFF);

      run_random(270);
      drain_reports();

      send_idle_pct = 53;
      recv_idle_pct = 36;
      run_random(270);
      drain_reports();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(260);

      // long clean run to final, then bad cycles that must not move it
      idx = $urandom;
      for (i = 0; i < 24; i++) begin
         send_pattern_cycle(idx + i, tracker_sb.offset_now(), 1'b0);
      end
      for (i = 24; i < 30; i++) begin
         send_pattern_cycle(idx + i, tracker_sb.offset_now(), 1'b1);
      end
      send_cycle(idx + 30, 16'd0, 16'd9);
      send_pattern_cycle(idx + 31, tracker_sb.offset_now(), 1'b0);

      drain_reports();
      repeat (8) @(negedge clock);
      if (tracker_sb.mismatch_count == 0 && tracker_sb.reports_pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
